[design/btir_pkg.sv]
// Shared types and constants for the broadcast tile index remap block.
// No dependencies; all other design files but btir_div use it by scope.
package btir_pkg;

  localparam int IDX_W      = 32;  // tile index and stride width
  localparam int RANK_W     = 5;   // holds a dimension count up to 31
  localparam int COUNT_W    = 4;
  localparam int MASK_W     = 8;
  localparam int DIMS_REG_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT  = 3'd0,
    REG_BCAST_MASK = 3'd1,
    REG_TDIMS_LO   = 3'd2,
    REG_TDIMS_HI   = 3'd3,
    REG_SDIMS_LO   = 3'd4,
    REG_SDIMS_HI   = 3'd5
  } cfg_reg_t;

  // Per-dimension view handed from the config block to the sequencer.
  typedef struct packed {
    logic              busy;     // strides being rebuilt
    logic [RANK_W-1:0] rank;     // dimensions in use, saturated
    logic              bcast;
    logic [IDX_W-1:0]  tdim;
    logic [IDX_W-1:0]  tstride;
    logic [IDX_W-1:0]  sstride;
  } dim_info_t;

endpackage

[design/btir_if.sv]
// Valid/ready channel interfaces for the index remap block.
// Depends on btir_pkg for the index width.
interface btir_in_if;
  logic                       valid;
  logic                       ready;
  logic [btir_pkg::IDX_W-1:0] tile_index;

  modport source (output valid, output tile_index, input ready);
  modport sink   (input valid, input tile_index, output ready);
endinterface

interface btir_out_if;
  logic                       valid;
  logic                       ready;
  logic [btir_pkg::IDX_W-1:0] same_tile_index;
  logic [btir_pkg::IDX_W-1:0] source_tile_index;

  modport source (output valid, output same_tile_index, output source_tile_index,
                  input ready);
  modport sink   (input valid, input same_tile_index, input source_tile_index,
                  output ready);
endinterface

[design/btir_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Has no dependencies on the other design files.
module btir_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r;
  logic [W:0]    rem_sh;
  logic          last_step;

  always_comb begin
    rem_sh = {rem_r, quo_r[W-1]};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = W'(rem_sh - {1'b0, dvs_r});
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  assign last_step = busy_r && !start && (cnt_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        busy_r <= !last_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[design/btir_cfg.sv]
// Configuration registers and stride table, rebuilt one dimension per cycle
// after reset and after every accepted register write. Depends on btir_pkg.
module btir_cfg #(
  parameter int MAX_DIMS  = 8,
  parameter int DIM_WIDTH = 16,
  parameter int CNT_W     = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [btir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btir_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [CNT_W-1:0]                 dim_sel,
  output btir_pkg::dim_info_t              info
);

  localparam int IX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DVEC_W = 2 * btir_pkg::DIMS_REG_W;
  localparam int SH_W   = $clog2(MAX_DIMS * DIM_WIDTH + 1);
  localparam int IW     = btir_pkg::IDX_W;
  localparam int RW     = btir_pkg::RANK_W;

  function automatic logic [btir_pkg::DIMS_REG_W-1:0] unit_fields();
    logic [btir_pkg::DIMS_REG_W-1:0] v;
    v = '0;
    for (int p = 0; p < btir_pkg::DIMS_REG_W; p += DIM_WIDTH) begin
      v[p] = 1'b1;
    end
    return v;
  endfunction

  localparam logic [btir_pkg::DIMS_REG_W-1:0] UNIT = unit_fields();

  // Field i of a 128-bit dimension vector; fields past the top read as zero.
  function automatic logic [DIM_WIDTH-1:0] dim_of(input logic [DVEC_W-1:0] vec,
                                                  input logic [CNT_W-1:0]  i);
    logic [SH_W-1:0]   sh;
    logic [DVEC_W-1:0] v;
    sh = SH_W'(SH_W'(i) * SH_W'(DIM_WIDTH));
    v  = vec >> sh;
    return v[DIM_WIDTH-1:0];
  endfunction

  logic [btir_pkg::COUNT_W-1:0]    count_r;
  logic [btir_pkg::MASK_W-1:0]     mask_r;
  logic [btir_pkg::DIMS_REG_W-1:0] tlo_r, thi_r, slo_r, shi_r;
  logic                            reb_r;
  logic [IX_W-1:0]                 ridx_r;
  logic [IW-1:0]                   tprod_r, sprod_r;
  logic [IW-1:0]                   tstr_r [MAX_DIMS];
  logic [IW-1:0]                   sstr_r [MAX_DIMS];

  logic                 wr_ok;
  logic [DIM_WIDTH-1:0] tdim_reb, sdim_reb;
  logic [IX_W-1:0]      sel;
  logic [RW-1:0]        sel_ext;
  logic [RW-1:0]        cnt_ext;

  assign wr_ok    = cfg_we &&
                    (cfg_index <= btir_pkg::CFG_IDX_W'(btir_pkg::REG_SDIMS_HI));
  assign tdim_reb = dim_of({thi_r, tlo_r}, CNT_W'(ridx_r));
  assign sdim_reb = dim_of({shi_r, slo_r}, CNT_W'(ridx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= btir_pkg::COUNT_W'(1);
      mask_r  <= '0;
      tlo_r   <= UNIT;
      thi_r   <= UNIT;
      slo_r   <= UNIT;
      shi_r   <= UNIT;
      reb_r   <= 1'b1;
      ridx_r  <= '0;
      tprod_r <= IW'(1);
      sprod_r <= IW'(1);
    end else begin
      // any accepted write restarts the stride pass from dimension zero
      if (wr_ok) begin
        reb_r   <= 1'b1;
        ridx_r  <= '0;
        tprod_r <= IW'(1);
        sprod_r <= IW'(1);
        case (cfg_index)
          btir_pkg::REG_DIM_COUNT:  count_r <= cfg_data[btir_pkg::COUNT_W-1:0];
          btir_pkg::REG_BCAST_MASK: mask_r  <= cfg_data[btir_pkg::MASK_W-1:0];
          btir_pkg::REG_TDIMS_LO:   tlo_r   <= cfg_data;
          btir_pkg::REG_TDIMS_HI:   thi_r   <= cfg_data;
          btir_pkg::REG_SDIMS_LO:   slo_r   <= cfg_data;
          btir_pkg::REG_SDIMS_HI:   shi_r   <= cfg_data;
          default: ;
        endcase
      end else if (reb_r) begin
        tprod_r <= IW'(tprod_r * tdim_reb);
        sprod_r <= IW'(sprod_r * sdim_reb);
        ridx_r  <= ridx_r + 1'b1;
        if (ridx_r == IX_W'(MAX_DIMS - 1)) begin
          reb_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reb_r) begin
      tstr_r[ridx_r] <= tprod_r;
      sstr_r[ridx_r] <= sprod_r;
    end
  end

  assign sel     = dim_sel[IX_W-1:0];
  assign sel_ext = RW'(dim_sel);
  assign cnt_ext = RW'(count_r);

  always_comb begin
    info.busy    = reb_r;
    info.rank    = (cnt_ext > RW'(MAX_DIMS)) ? RW'(MAX_DIMS) : cnt_ext;
    info.bcast   = (sel_ext < RW'(btir_pkg::MASK_W)) ?
                   mask_r[sel_ext[$clog2(btir_pkg::MASK_W)-1:0]] : 1'b0;
    info.tdim    = IW'(dim_of({thi_r, tlo_r}, dim_sel));
    info.tstride = tstr_r[sel];
    info.sstride = sstr_r[sel];
  end

endmodule

[design/broadcast_tile_index_remap.sv]
// Broadcast tile index remap: sequencer around one shared iterative divider.
// Depends on btir_pkg, btir_if, btir_cfg and btir_div.
//
// Usage: in_ch carries a linear tile index of the indexed tensor; out_ch
// returns it unchanged together with the index of the matching tile in the
// broadcast source tensor. Both channels use valid/ready; an item moves on a
// clock edge with valid and ready high. The cfg port writes a register on
// any edge with cfg_we high; index beyond the list is ignored.
// Each dimension in use is skipped when it is broadcast or has a zero size
// or stride; otherwise it takes two divisions on the shared divider (index
// by stride, then quotient by size), a multiply and an accumulate. One item
// is in work at a time.
// After reset, and after each accepted register write, the stride table is
// rebuilt while in_ch.ready stays low. A finished result waits in the output
// register while the receiver stalls; the next item can be accepted
// meanwhile, and it holds in its last step until the register frees.
module broadcast_tile_index_remap #(
  parameter int MAX_DIMS  = 8,
  parameter int DIM_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  btir_in_if.sink                         in_ch,
  btir_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [btir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btir_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_DIMS + 1);
  localparam int IW    = btir_pkg::IDX_W;
  localparam int RW    = btir_pkg::RANK_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV1, S_DIV2, S_MUL, S_ACC, S_FINISH
  } state_t;

  state_t               state_r;
  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        sum_r;
  logic [IW-1:0]        prod_r;
  logic [CNT_W-1:0]     dim_r;
  logic [DIM_WIDTH-1:0] coord_r;
  logic                 div_start_r;
  logic [IW-1:0]        div_a_r, div_b_r;
  logic                 out_valid_r;
  logic [IW-1:0]        out_same_r, out_src_r;

  btir_pkg::dim_info_t  info;
  logic                 div_busy, div_done;
  logic [IW-1:0]        div_quo, div_rem;
  logic                 in_ready;
  logic                 dim_skip;

  btir_cfg #(
    .MAX_DIMS  (MAX_DIMS),
    .DIM_WIDTH (DIM_WIDTH),
    .CNT_W     (CNT_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dim_sel   (dim_r),
    .info      (info)
  );

  btir_div #(.W(IW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (div_a_r),
    .divisor   (div_b_r),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ready = (state_r == S_IDLE) && !info.busy;
  // coordinate is zero, nothing to add
  assign dim_skip = info.bcast || info.tdim == '0 || info.tstride == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      sum_r       <= '0;
      prod_r      <= '0;
      dim_r       <= '0;
      coord_r     <= '0;
      div_start_r <= 1'b0;
      div_a_r     <= '0;
      div_b_r     <= '0;
      out_valid_r <= 1'b0;
      out_same_r  <= '0;
      out_src_r   <= '0;
    end else begin
      div_start_r <= ((state_r == S_CHECK) && (RW'(dim_r) < info.rank) && !dim_skip) ||
                     ((state_r == S_DIV1) && div_done);
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ready) begin
            idx_r   <= in_ch.tile_index;
            sum_r   <= '0;
            dim_r   <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (RW'(dim_r) >= info.rank) begin
            state_r <= S_FINISH;
          end else if (dim_skip) begin
            dim_r <= dim_r + 1'b1;
          end else begin
            div_a_r <= idx_r;
            div_b_r <= info.tstride;
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            div_a_r <= div_quo;
            div_b_r <= info.tdim;
            state_r <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            coord_r <= div_rem[DIM_WIDTH-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= IW'(coord_r * info.sstride);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + prod_r;
          dim_r   <= dim_r + 1'b1;
          state_r <= S_CHECK;
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_same_r  <= idx_r;
            out_src_r   <= sum_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.same_tile_index   = out_same_r;
  assign out_ch.source_tile_index = out_src_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_busy)
    else $error("divider started while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a divide step");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result loaded outside finish step");

  a_acc_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |=> (state_r == S_CHECK))
    else $error("accumulate not followed by next dimension");

endmodule
